FILE: rtl/ffac_pkg.sv
// ----------------------------------------------------------------------------
// ffac_pkg
// shared constants, codes and types of the flame and field alarm controller
// ----------------------------------------------------------------------------
package ffac_pkg;

    localparam int LEVEL_W     = 12;
    localparam int CAL_SAMPLES = 50;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;
    localparam logic [23:0]        RECAL_MAX = '1;

    // calibration accumulators and sample counter
    localparam int SUM_W = $clog2(CAL_SAMPLES * 4095 + 1);
    localparam int CNT_W = $clog2(CAL_SAMPLES + 1);

    // exact divide by CAL_SAMPLES through a reciprocal multiply
    localparam int RECIP_W   = SUM_W + 1;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam int CAL_SHIFT = SUM_W + $clog2(CAL_SAMPLES);
    localparam logic [RECIP_W-1:0] CAL_RECIP =
        RECIP_W'(((64'd1 << CAL_SHIFT) + CAL_SAMPLES - 1) / CAL_SAMPLES);

    // request kinds
    localparam logic [2:0] REQ_SAMPLE    = 3'd0;
    localparam logic [2:0] REQ_TICK      = 3'd1;
    localparam logic [2:0] REQ_ACK       = 3'd2;
    localparam logic [2:0] REQ_UNSILENCE = 3'd3;
    localparam logic [2:0] REQ_CALIBRATE = 3'd4;

    // register indexes
    localparam logic [2:0] CFG_FLAME_FLOOR  = 3'd0;
    localparam logic [2:0] CFG_FLAME_MARGIN = 3'd1;
    localparam logic [2:0] CFG_FIELD_MARGIN = 3'd2;
    localparam logic [2:0] CFG_CONFIRM      = 3'd3;
    localparam logic [2:0] CFG_BLINK_PERIOD = 3'd4;
    localparam logic [2:0] CFG_RECAL_PERIOD = 3'd5;

    localparam int CFG_DATA_W = 24;

    // one result, highest bit first
    typedef struct packed {
        logic field_changed;
        logic fire_changed;
        logic calibrating;
        logic muted;
        logic field_led;
        logic buzzer;
        logic fire_led;
        logic field_alarm;
        logic fire_alarm;
    } result_t;

endpackage

FILE: rtl/ffac_result_buf.sv
// ----------------------------------------------------------------------------
// ffac_result_buf
// two-entry result buffer between the state update and the output stream
// ----------------------------------------------------------------------------
module ffac_result_buf (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  ffac_pkg::result_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output ffac_pkg::result_t out_data
);
    import ffac_pkg::*;

    result_t     head_reg;
    result_t     tail_reg;
    logic [1:0]  count_reg;
    logic        push;
    logic        pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = head_reg;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push && !pop) begin
            if (count_reg == 2'd0) begin
                head_reg <= in_data;
            end else begin
                tail_reg <= in_data;
            end
        end else if (pop && !push) begin
            head_reg <= tail_reg;
        end else if (pop && push) begin
            if (count_reg == 2'd1) begin
                head_reg <= in_data;
            end else begin
                head_reg <= tail_reg;
                tail_reg <= in_data;
            end
        end
    end

endmodule

FILE: rtl/flame_field_alarm_controller_core.sv
// ----------------------------------------------------------------------------
// flame_field_alarm_controller_core
// flame and hall field alarm with debounce, blinking alert and calibration
// ----------------------------------------------------------------------------
// results: a result is written into the result buffer when its request is accepted
// throughput: one request per cycle while the result buffer has room, set by the single state update stage
// a two-entry result buffer keeps s_tready high while one result waits
// reset: registers at defaults, thresholds open, calibration pass running
// ----------------------------------------------------------------------------
module flame_field_alarm_controller_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // flame_digital, flame_level, field_level
    input  logic [31:0]                    s_tdata,
    // req_type
    input  logic [2:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // fire_alarm, field_alarm, fire_led, buzzer, field_led, muted,
    // calibrating, fire_changed, field_changed
    output logic [15:0]                    m_tdata,
    input  logic                           cfg_we,
    input  logic [2:0]                     cfg_index,
    input  logic [ffac_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ffac_pkg::*;

    logic [LEVEL_W-1:0] flame_floor_reg;
    logic [LEVEL_W-1:0] flame_margin_reg;
    logic [LEVEL_W-1:0] field_margin_reg;
    logic [7:0]         confirm_count_reg;
    logic [15:0]        blink_period_reg;
    logic [23:0]        recal_period_reg;

    logic [7:0]         stable_count_reg, stable_count_next;
    logic               fire_flag_reg, fire_flag_next;
    logic               field_flag_reg, field_flag_next;
    logic               silence_reg, silence_next;
    logic               blink_phase_reg, blink_phase_next;
    logic [15:0]        blink_timer_reg, blink_timer_next;
    logic [23:0]        recal_timer_reg, recal_timer_next;
    logic               cal_active_reg, cal_active_next;
    logic [CNT_W-1:0]   cal_seen_reg, cal_seen_next;
    logic [SUM_W-1:0]   flame_sum_reg, flame_sum_next;
    logic [SUM_W-1:0]   field_sum_reg, field_sum_next;
    logic [LEVEL_W-1:0] flame_thr_reg, flame_thr_next;
    logic [LEVEL_W-1:0] field_thr_reg, field_thr_next;

    logic               accept;
    logic [2:0]         req_type;
    logic               flame_digital;
    logic [LEVEL_W-1:0] flame_level;
    logic [LEVEL_W-1:0] field_level;

    logic [SUM_W-1:0]   flame_acc;
    logic [SUM_W-1:0]   field_acc;
    logic [CNT_W-1:0]   seen_inc;
    logic [PROD_W-1:0]  flame_prod;
    logic [PROD_W-1:0]  field_prod;
    logic [LEVEL_W-1:0] ambient;
    logic [LEVEL_W-1:0] baseline;
    logic [LEVEL_W-1:0] flame_cut;
    logic [LEVEL_W:0]   field_sum_thr;
    logic [7:0]         need;
    logic               fire_now;
    logic [16:0]        blink_inc;
    logic [15:0]        period;
    logic [23:0]        recal_inc;
    logic               fire_chg;
    logic               field_chg;
    logic               lamp;
    result_t            result;
    result_t            out_result;
    logic               buf_ready;

    assign req_type      = s_tuser;
    assign flame_digital = s_tdata[0];
    assign flame_level   = s_tdata[12:1];
    assign field_level   = s_tdata[24:13];
    assign s_tready      = buf_ready;
    assign accept        = s_tvalid && buf_ready;

    // calibration arithmetic
    assign flame_acc  = flame_sum_reg + SUM_W'(flame_level);
    assign field_acc  = field_sum_reg + SUM_W'(field_level);
    assign seen_inc   = cal_seen_reg + CNT_W'(1);
    assign flame_prod = PROD_W'(flame_acc) * PROD_W'(CAL_RECIP);
    assign field_prod = PROD_W'(field_acc) * PROD_W'(CAL_RECIP);
    assign ambient    = flame_prod[CAL_SHIFT +: LEVEL_W];
    assign baseline   = field_prod[CAL_SHIFT +: LEVEL_W];
    assign flame_cut  = (ambient > flame_margin_reg) ? (ambient - flame_margin_reg)
                                                     : '0;
    assign field_sum_thr = {1'b0, baseline} + {1'b0, field_margin_reg};

    assign need      = (confirm_count_reg == 8'd0) ? 8'd1 : confirm_count_reg;
    assign fire_now  = flame_digital || (flame_level < flame_thr_reg);
    assign period    = (blink_period_reg == 16'd0) ? 16'd1 : blink_period_reg;
    assign blink_inc = {1'b0, blink_timer_reg} + 17'd1;
    assign recal_inc = (recal_timer_reg != RECAL_MAX) ? (recal_timer_reg + 24'd1)
                                                       : recal_timer_reg;

    always_comb begin
        stable_count_next = stable_count_reg;
        fire_flag_next    = fire_flag_reg;
        field_flag_next   = field_flag_reg;
        silence_next      = silence_reg;
        blink_phase_next  = blink_phase_reg;
        blink_timer_next  = blink_timer_reg;
        recal_timer_next  = recal_timer_reg;
        cal_active_next   = cal_active_reg;
        cal_seen_next     = cal_seen_reg;
        flame_sum_next    = flame_sum_reg;
        field_sum_next    = field_sum_reg;
        flame_thr_next    = flame_thr_reg;
        field_thr_next    = field_thr_reg;
        fire_chg          = 1'b0;
        field_chg         = 1'b0;

        case (req_type)
            REQ_SAMPLE: begin
                if (cal_active_reg) begin
                    if (seen_inc >= CNT_W'(CAL_SAMPLES)) begin
                        flame_thr_next   = (flame_cut < flame_floor_reg) ? flame_floor_reg
                                                                         : flame_cut;
                        field_thr_next   = field_sum_thr[LEVEL_W] ? LEVEL_MAX
                                                                  : field_sum_thr[LEVEL_W-1:0];
                        cal_active_next  = 1'b0;
                        cal_seen_next    = '0;
                        flame_sum_next   = '0;
                        field_sum_next   = '0;
                        recal_timer_next = '0;
                    end else begin
                        cal_seen_next  = seen_inc;
                        flame_sum_next = flame_acc;
                        field_sum_next = field_acc;
                    end
                end else begin
                    if (fire_now) begin
                        if (stable_count_reg < need) begin
                            stable_count_next = stable_count_reg + 8'd1;
                        end
                    end else begin
                        stable_count_next = 8'd0;
                    end
                    fire_flag_next  = (stable_count_next >= need);
                    fire_chg        = (fire_flag_next != fire_flag_reg);
                    field_flag_next = (field_level > field_thr_reg);
                    field_chg       = (field_flag_next != field_flag_reg);
                    if (!(fire_flag_next && !silence_reg)) begin
                        blink_phase_next = 1'b0;
                        blink_timer_next = 16'd0;
                    end
                end
            end
            REQ_TICK: begin
                if (!cal_active_reg) begin
                    if (fire_flag_reg && !silence_reg) begin
                        if (blink_inc >= {1'b0, period}) begin
                            blink_phase_next = !blink_phase_reg;
                            blink_timer_next = 16'd0;
                        end else begin
                            blink_timer_next = blink_inc[15:0];
                        end
                    end else begin
                        blink_phase_next = 1'b0;
                        blink_timer_next = 16'd0;
                    end
                    recal_timer_next = recal_inc;
                    if (recal_inc > recal_period_reg) begin
                        cal_active_next = 1'b1;
                        cal_seen_next   = '0;
                        flame_sum_next  = '0;
                        field_sum_next  = '0;
                    end
                end
            end
            REQ_ACK: begin
                silence_next     = 1'b1;
                blink_phase_next = 1'b0;
                blink_timer_next = 16'd0;
            end
            REQ_UNSILENCE: begin
                silence_next = 1'b0;
            end
            REQ_CALIBRATE: begin
                cal_active_next = 1'b1;
                cal_seen_next   = '0;
                flame_sum_next  = '0;
                field_sum_next  = '0;
            end
            default: begin
            end
        endcase

        lamp                 = fire_flag_next && !silence_next && blink_phase_next;
        result.fire_alarm    = fire_flag_next;
        result.field_alarm   = field_flag_next;
        result.fire_led      = lamp;
        result.buzzer        = lamp;
        result.field_led     = field_flag_next && !silence_next;
        result.muted         = silence_next;
        result.calibrating   = cal_active_next;
        result.fire_changed  = fire_chg;
        result.field_changed = field_chg;
    end

    // register bank
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flame_floor_reg   <= 12'd50;
            flame_margin_reg  <= 12'd100;
            field_margin_reg  <= 12'd300;
            confirm_count_reg <= 8'd5;
            blink_period_reg  <= 16'd500;
            recal_period_reg  <= 24'd300000;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_FLAME_FLOOR:  flame_floor_reg   <= cfg_data[LEVEL_W-1:0];
                CFG_FLAME_MARGIN: flame_margin_reg  <= cfg_data[LEVEL_W-1:0];
                CFG_FIELD_MARGIN: field_margin_reg  <= cfg_data[LEVEL_W-1:0];
                CFG_CONFIRM:      confirm_count_reg <= cfg_data[7:0];
                CFG_BLINK_PERIOD: blink_period_reg  <= cfg_data[15:0];
                CFG_RECAL_PERIOD: recal_period_reg  <= cfg_data[23:0];
                default: begin
                end
            endcase
        end
    end

    // alarm state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stable_count_reg <= 8'd0;
            fire_flag_reg    <= 1'b0;
            field_flag_reg   <= 1'b0;
            silence_reg      <= 1'b0;
            blink_phase_reg  <= 1'b0;
            blink_timer_reg  <= 16'd0;
            recal_timer_reg  <= 24'd0;
            cal_active_reg   <= 1'b1;
            cal_seen_reg     <= '0;
            flame_sum_reg    <= '0;
            field_sum_reg    <= '0;
            flame_thr_reg    <= '0;
            field_thr_reg    <= LEVEL_MAX;
        end else if (accept) begin
            stable_count_reg <= stable_count_next;
            fire_flag_reg    <= fire_flag_next;
            field_flag_reg   <= field_flag_next;
            silence_reg      <= silence_next;
            blink_phase_reg  <= blink_phase_next;
            blink_timer_reg  <= blink_timer_next;
            recal_timer_reg  <= recal_timer_next;
            cal_active_reg   <= cal_active_next;
            cal_seen_reg     <= cal_seen_next;
            flame_sum_reg    <= flame_sum_next;
            field_sum_reg    <= field_sum_next;
            flame_thr_reg    <= flame_thr_next;
            field_thr_reg    <= field_thr_next;
        end
    end

    ffac_result_buf u_result_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (buf_ready),
        .in_data   (result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = {7'd0, out_result};

endmodule

FILE: rtl/ffac_checker.sv
// ----------------------------------------------------------------------------
// ffac_checker
// port-level checks of the flame and field alarm controller
// ----------------------------------------------------------------------------
module ffac_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // nothing pending right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

    // input stalls only while results are queued
    assert property (@(posedge aclk) disable iff (!aresetn) !s_tready |-> m_tvalid)
        else $error("input stalled with empty result buffer");

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // lamp and buzzer only with an unsilenced fire
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2] == m_tdata[3]) && (!m_tdata[2] || (m_tdata[0] && !m_tdata[5])))
        else $error("fire lamp or buzzer inconsistent");

    // silence turns off the field lamp
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[5] |-> !m_tdata[4])
        else $error("field lamp on while silenced");

endmodule

bind flame_field_alarm_controller_core ffac_checker u_ffac_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
